@@ hdl/uvs_pkg.sv @@
// shared types and constants of the uv sphere element generator
`default_nettype none
package uvs_pkg;

    // request codes
    localparam logic [2:0] OP_RING_VTX = 3'd0;
    localparam logic [2:0] OP_TOP_POLE = 3'd1;
    localparam logic [2:0] OP_BOT_POLE = 3'd2;
    localparam logic [2:0] OP_TOP_CAP  = 3'd3;
    localparam logic [2:0] OP_BAND     = 3'd4;
    localparam logic [2:0] OP_BOT_CAP  = 3'd5;

    // configuration register indexes
    localparam logic [2:0] CFG_RADIUS     = 3'd0;
    localparam logic [2:0] CFG_SLICES     = 3'd1;
    localparam logic [2:0] CFG_STACKS     = 3'd2;
    localparam logic [2:0] CFG_COL_ANGLE  = 3'd3;
    localparam logic [2:0] CFG_RING_ANGLE = 3'd4;
    localparam logic [2:0] CFG_U_STEP     = 3'd5;
    localparam logic [2:0] CFG_V_STEP     = 3'd6;

    // sine unit timing and fixed-point constants
    localparam int SIN_LAT      = 19;
    localparam int HORNER_STEPS = 5;
    localparam logic [30:0] Q30_ONE     = 31'h4000_0000;
    localparam logic [30:0] HALF_PI_Q30 = 31'd1686629713;

    // per-request control word carried alongside the sine pipeline
    typedef struct packed {
        logic        is_vtx;
        logic        bad;
        logic [23:0] pos_y;
        logic [15:0] norm_y;
        logic [16:0] tex_u;
        logic [16:0] tex_v;
        logic [16:0] idx_a;
        logic [16:0] idx_b;
        logic [16:0] idx_c;
    } ctl_t;

    // taylor divisors, innermost term first
    function automatic logic [6:0] horner_div(input int k);
        logic [6:0] d;
        case (k)
            0:       d = 7'd110;
            1:       d = 7'd72;
            2:       d = 7'd42;
            3:       d = 7'd20;
            default: d = 7'd6;
        endcase
        return d;
    endfunction

    // floor(2^32 / divisor), low by at most one after truncation
    function automatic logic [29:0] horner_recip(input int k);
        logic [29:0] m;
        case (k)
            0:       m = 30'd39045157;
            1:       m = 30'd59652323;
            2:       m = 30'd102261126;
            3:       m = 30'd214748364;
            default: m = 30'd715827882;
        endcase
        return m;
    endfunction

endpackage
`default_nettype wire

@@ hdl/uvs_sine.sv @@
// pipelined fixed-point sine magnitude, quarter-wave fold and taylor series
`default_nettype none
module uvs_sine #(
    parameter int ANGLE_BITS = 16
) (
    input  wire logic                  clk,
    input  wire logic                  en,
    input  wire logic [ANGLE_BITS-1:0] angle,
    output logic      [30:0]           mag,
    output logic                       neg
);
    import uvs_pkg::*;

    localparam int QB = ANGLE_BITS - 2;
    localparam int XW = QB + 32;

    typedef struct packed {
        logic [30:0] x;
        logic [31:0] x2;
        logic        neg;
    } carry_t;

    logic [QB:0]   r1_reg;
    logic          neg1_reg;
    logic [QB:0]   r_fold;
    logic [XW-1:0] x_prod;
    logic [XW-1:0] x_round;
    carry_t        c2_reg;
    logic [61:0]   x2_prod;
    carry_t        c3_reg;

    logic [31:0] p_reg  [HORNER_STEPS];
    carry_t      ca_reg [HORNER_STEPS];
    logic [29:0] qe_reg [HORNER_STEPS];
    logic [31:0] pb_reg [HORNER_STEPS];
    carry_t      cb_reg [HORNER_STEPS];
    logic [30:0] t_reg  [HORNER_STEPS];
    carry_t      cc_reg [HORNER_STEPS];

    logic [61:0] s_prod;
    logic [31:0] s_full;
    logic [30:0] mag_reg;
    logic        neg_reg;

    // fold the angle into the first quadrant
    assign r_fold = angle[QB] ? (((QB+1)'(1) << QB) - {1'b0, angle[QB-1:0]})
                              : {1'b0, angle[QB-1:0]};

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            r1_reg   <= r_fold;
            neg1_reg <= angle[QB+1];
        end
    end

    // radians in q30, rounded half up
    assign x_prod  = XW'(r1_reg) * XW'(HALF_PI_Q30);
    assign x_round = x_prod + (XW'(1) << (QB - 1));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c2_reg.x   <= x_round[QB+30:QB];
            c2_reg.x2  <= '0;
            c2_reg.neg <= neg1_reg;
        end
    end

    // x squared
    assign x2_prod = 62'(c2_reg.x) * 62'(c2_reg.x);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c3_reg.x   <= c2_reg.x;
            c3_reg.x2  <= x2_prod[61:30];
            c3_reg.neg <= c2_reg.neg;
        end
    end

    // horner steps: multiply, reciprocal estimate, correct and subtract
    for (genvar k = 0; k < HORNER_STEPS; k++)
    begin : g_step
        logic [30:0] t_in;
        carry_t      c_in;
        logic [62:0] p_prod;
        logic [61:0] q_prod;
        logic [36:0] qd_prod;
        logic [31:0] rem;
        logic [29:0] q_fix;

        if (k == 0)
        begin : g_first
            assign t_in = Q30_ONE;
            assign c_in = c3_reg;
        end
        else
        begin : g_next
            assign t_in = t_reg[k-1];
            assign c_in = cc_reg[k-1];
        end

        assign p_prod  = 63'(c_in.x2) * 63'(t_in);
        assign q_prod  = 62'(p_reg[k]) * 62'(horner_recip(k));
        assign qd_prod = 37'(qe_reg[k]) * 37'(horner_div(k));
        assign rem     = pb_reg[k] - qd_prod[31:0];
        assign q_fix   = (rem >= 32'(horner_div(k))) ? (qe_reg[k] + 30'd1) : qe_reg[k];

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                p_reg[k]  <= p_prod[61:30];
                ca_reg[k] <= c_in;
                qe_reg[k] <= q_prod[61:32];
                pb_reg[k] <= p_reg[k];
                cb_reg[k] <= ca_reg[k];
                t_reg[k]  <= Q30_ONE - 31'(q_fix);
                cc_reg[k] <= cb_reg[k];
            end
        end
    end

    // final x*t, limited to one
    assign s_prod = 62'(cc_reg[HORNER_STEPS-1].x) * 62'(t_reg[HORNER_STEPS-1]);
    assign s_full = s_prod[61:30];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            mag_reg <= (s_full > 32'(Q30_ONE)) ? Q30_ONE : s_full[30:0];
            neg_reg <= cc_reg[HORNER_STEPS-1].neg;
        end
    end

    assign mag = mag_reg;
    assign neg = neg_reg;

endmodule
`default_nettype wire

@@ hdl/uv_sphere_mesh_generator_core.sv @@
// top level of the uv sphere element generator
// Usage:
//  - configuration: cfg_we writes cfg_data into register cfg_index (radius, slices,
//    stacks, column angle step, ring angle step, u step, v step); write only while
//    the block is idle
//  - request channel: in_valid with op, ring, column, half; a word is taken at a
//    clock edge where in_valid is high and in_stall is low
//  - result channel: out_valid with position, normal, texture, indices and
//    bad_request; the receiver holds out_stall high to keep the word in place
//  - every request yields exactly one result word
//  - pipeline: 21 pipeline registers plus the output register between acceptance
//    and out_valid, set by the 19-stage sine unit (quarter-wave fold, conversion
//    to radians, x squared, five taylor steps of three stages each, final product)
//    and two stages for direction products and radius scaling
//  - throughput: one word per cycle while the receiver takes words
//  - stall: a held output word freezes the whole pipeline, in_stall follows
//    from out_valid and out_stall, nothing is dropped or repeated
//  - reset: clears all valid bits and loads the default registers
//    (radius 1.0, 16 slices, 8 stacks, steps of 1/16 and 1/8)
`default_nettype none
module uv_sphere_mesh_generator_core #(
    parameter int MAX_SLICES = 256,
    parameter int MAX_STACKS = 256,
    parameter int ANGLE_BITS = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               cfg_we,
    input  wire logic        [2:0]  cfg_index,
    input  wire logic        [16:0] cfg_data,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic        [2:0]  op,
    input  wire logic        [8:0]  ring,
    input  wire logic        [8:0]  column,
    input  wire logic               half,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed      [23:0] pos_x,
    output logic signed      [23:0] pos_y,
    output logic signed      [23:0] pos_z,
    output logic signed      [15:0] norm_x,
    output logic signed      [15:0] norm_y,
    output logic signed      [15:0] norm_z,
    output logic             [16:0] tex_u,
    output logic             [16:0] tex_v,
    output logic             [16:0] index_a,
    output logic             [16:0] index_b,
    output logic             [16:0] index_c,
    output logic                    bad_request
);
    import uvs_pkg::*;

    localparam int QB      = ANGLE_BITS - 2;
    localparam int CTL_LAT = SIN_LAT + 2;
    localparam int SH_L    = (ANGLE_BITS >= 16) ? (ANGLE_BITS - 16) : 0;
    localparam int SH_R    = (ANGLE_BITS < 16) ? (16 - ANGLE_BITS) : 0;
    localparam int TW      = ANGLE_BITS + 16;

    // configuration registers
    logic [15:0] radius_reg;
    logic [8:0]  slices_reg;
    logic [8:0]  stacks_reg;
    logic [15:0] col_angle_reg;
    logic [15:0] ring_angle_reg;
    logic [16:0] u_step_reg;
    logic [16:0] v_step_reg;

    // pipeline control
    logic               en;
    logic [CTL_LAT-1:0] vld_reg;
    ctl_t               ctl_reg [CTL_LAT];
    logic               out_valid_reg;

    // request decode
    logic [10:0]           sl;
    logic [10:0]           st;
    logic [10:0]           rv;
    logic [21:0]           st_p1;
    logic [21:0]           south;
    logic [21:0]           base;
    logic [21:0]           v00;
    logic [21:0]           v10;
    logic [25:0]           u_prod;
    logic [25:0]           vd_prod;
    logic [24:0]           ph_turn;
    logic [24:0]           th_turn;
    logic [TW-1:0]         ph_wide;
    logic [TW-1:0]         th_wide;
    logic [ANGLE_BITS-1:0] ph;
    logic [ANGLE_BITS-1:0] th;
    logic [ANGLE_BITS-1:0] ph_q;
    logic [ANGLE_BITS-1:0] th_q;
    ctl_t                  ctl_next;

    // sine outputs
    logic [30:0] sp_mag, cp_mag, sn_mag, cs_mag;
    logic        sp_neg, cp_neg, sn_neg, cs_neg;

    // direction stage
    logic [61:0] dx_prod;
    logic [61:0] dz_prod;
    logic [30:0] dx_reg, dz_reg, cp_reg;
    logic        sx_reg, sz_reg, sy_reg;

    // scaling stage
    logic [46:0] px_prod, py_prod, pz_prod;
    logic [22:0] px_reg, py_reg, pz_reg;
    logic        xn_reg, yn_reg, zn_reg;
    logic [15:0] nx_reg, ny_reg, nz_reg;

    // output word
    logic [23:0] pos_x_reg, pos_y_reg, pos_z_reg;
    logic [15:0] norm_x_reg, norm_y_reg, norm_z_reg;
    logic [16:0] tex_u_reg, tex_v_reg;
    logic [16:0] index_a_reg, index_b_reg, index_c_reg;
    logic        bad_reg;

    // normal field from a q30 direction magnitude, pointing inward
    function automatic logic [15:0] norm_field(input logic [30:0] m, input logic dneg);
        logic [31:0] rnd;
        logic [15:0] n;
        logic        nneg;
        rnd  = 32'(m) + 32'h0000_4000;
        n    = rnd[30:15];
        nneg = !dneg && (n != 16'd0);
        if (nneg)
            return 16'd0 - n;
        else if (n > 16'd32767)
            return 16'd32767;
        else
            return n;
    endfunction

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radius_reg     <= 16'd256;
            slices_reg     <= 9'd16;
            stacks_reg     <= 9'd8;
            col_angle_reg  <= 16'd4096;
            ring_angle_reg <= 16'd4096;
            u_step_reg     <= 17'd4096;
            v_step_reg     <= 17'd8192;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                CFG_RADIUS:     radius_reg     <= cfg_data[15:0];
                CFG_SLICES:     slices_reg     <= cfg_data[8:0];
                CFG_STACKS:     stacks_reg     <= cfg_data[8:0];
                CFG_COL_ANGLE:  col_angle_reg  <= cfg_data[15:0];
                CFG_RING_ANGLE: ring_angle_reg <= cfg_data[15:0];
                CFG_U_STEP:     u_step_reg     <= cfg_data;
                CFG_V_STEP:     v_step_reg     <= cfg_data;
                default:        ;
            endcase
        end
    end

    // clamped mesh sizes and vertex numbering
    always_comb
    begin
        if ({2'b0, slices_reg} < 11'd3)
            sl = 11'd3;
        else if ({2'b0, slices_reg} > 11'(MAX_SLICES))
            sl = 11'(MAX_SLICES);
        else
            sl = {2'b0, slices_reg};
        if ({2'b0, stacks_reg} < 11'd2)
            st = 11'd2;
        else if ({2'b0, stacks_reg} > 11'(MAX_STACKS))
            st = 11'(MAX_STACKS);
        else
            st = {2'b0, stacks_reg};
    end

    assign rv    = sl + 11'd1;
    assign st_p1 = 22'(st) + 22'd1;
    assign south = 22'd1 + st_p1 * 22'(rv);
    assign base  = south - 22'(rv);
    assign v00   = 22'd1 + 22'(ring) * 22'(rv) + 22'(column);
    assign v10   = v00 + 22'(rv);

    // texture products
    assign u_prod  = 26'(column) * 26'(u_step_reg);
    assign vd_prod = 26'(ring) * 26'(v_step_reg);

    // ring and column angles, rescaled to the sine resolution
    assign ph_turn = 25'(ring) * 25'(ring_angle_reg);
    assign th_turn = 25'(column) * 25'(col_angle_reg);
    assign ph_wide = ((TW'(ph_turn[15:0])) << SH_L) >> SH_R;
    assign th_wide = ((TW'(th_turn[15:0])) << SH_L) >> SH_R;
    assign ph      = ph_wide[ANGLE_BITS-1:0];
    assign th      = th_wide[ANGLE_BITS-1:0];
    assign ph_q    = ph + (ANGLE_BITS'(1) << QB);
    assign th_q    = th + (ANGLE_BITS'(1) << QB);

    // request decode into a control word
    always_comb
    begin
        ctl_next = '0;
        unique case (op)
            OP_RING_VTX:
            begin
                if ((11'(ring) > st) || (11'(column) > sl))
                    ctl_next.bad = 1'b1;
                else
                begin
                    ctl_next.is_vtx = 1'b1;
                    ctl_next.tex_u  = (u_prod > 26'd65536) ? 17'h10000 : u_prod[16:0];
                    ctl_next.tex_v  = (vd_prod > 26'd65536) ? 17'd0
                                                            : 17'h10000 - vd_prod[16:0];
                end
            end
            OP_TOP_POLE:
            begin
                ctl_next.pos_y  = {2'b0, radius_reg, 6'b0};
                ctl_next.norm_y = 16'h7FFF;
            end
            OP_BOT_POLE:
            begin
                ctl_next.pos_y  = 24'd0 - {2'b0, radius_reg, 6'b0};
                ctl_next.norm_y = 16'h8000;
                ctl_next.tex_v  = 17'h10000;
            end
            OP_TOP_CAP:
            begin
                if (11'(column) >= sl)
                    ctl_next.bad = 1'b1;
                else
                begin
                    ctl_next.idx_b = 17'(column) + 17'd2;
                    ctl_next.idx_c = 17'(column) + 17'd1;
                end
            end
            OP_BAND:
            begin
                if ((11'(ring) >= st) || (11'(column) >= sl))
                    ctl_next.bad = 1'b1;
                else
                begin
                    ctl_next.idx_b = v00[16:0] + 17'd1;
                    if (!half)
                    begin
                        ctl_next.idx_a = v00[16:0];
                        ctl_next.idx_c = v10[16:0];
                    end
                    else
                    begin
                        ctl_next.idx_a = v10[16:0];
                        ctl_next.idx_c = v10[16:0] + 17'd1;
                    end
                end
            end
            OP_BOT_CAP:
            begin
                if (11'(column) >= sl)
                    ctl_next.bad = 1'b1;
                else
                begin
                    ctl_next.idx_a = south[16:0];
                    ctl_next.idx_b = base[16:0] + 17'(column);
                    ctl_next.idx_c = base[16:0] + 17'(column) + 17'd1;
                end
            end
            default:
                ctl_next.bad = 1'b1;
        endcase
    end

    // pipeline advances unless a held output word is stalled
    assign en       = !(out_valid_reg && out_stall);
    assign in_stall = !en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            vld_reg       <= {vld_reg[CTL_LAT-2:0], in_valid};
            out_valid_reg <= vld_reg[CTL_LAT-1];
        end
    end

    // control word delay line
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ctl_reg[0] <= ctl_next;
            for (int i = 1; i < CTL_LAT; i++)
                ctl_reg[i] <= ctl_reg[i-1];
        end
    end

    // four sine lanes: sin phi, cos phi, sin theta, cos theta
    uvs_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin_phi (
        .clk(clk), .en(en), .angle(ph), .mag(sp_mag), .neg(sp_neg)
    );
    uvs_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cos_phi (
        .clk(clk), .en(en), .angle(ph_q), .mag(cp_mag), .neg(cp_neg)
    );
    uvs_sine #(.ANGLE_BITS(ANGLE_BITS)) u_sin_theta (
        .clk(clk), .en(en), .angle(th), .mag(sn_mag), .neg(sn_neg)
    );
    uvs_sine #(.ANGLE_BITS(ANGLE_BITS)) u_cos_theta (
        .clk(clk), .en(en), .angle(th_q), .mag(cs_mag), .neg(cs_neg)
    );

    // direction products, rounded half up
    assign dx_prod = 62'(sp_mag) * 62'(cs_mag) + (62'(1) << 29);
    assign dz_prod = 62'(sp_mag) * 62'(sn_mag) + (62'(1) << 29);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            dx_reg <= dx_prod[60:30];
            dz_reg <= dz_prod[60:30];
            cp_reg <= cp_mag;
            sx_reg <= sp_neg ^ cs_neg;
            sz_reg <= sp_neg ^ sn_neg;
            sy_reg <= cp_neg;
        end
    end

    // radius scaling and normals
    assign px_prod = 47'(radius_reg) * 47'(dx_reg) + (47'(1) << 23);
    assign py_prod = 47'(radius_reg) * 47'(cp_reg) + (47'(1) << 23);
    assign pz_prod = 47'(radius_reg) * 47'(dz_reg) + (47'(1) << 23);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg <= px_prod[46:24];
            py_reg <= py_prod[46:24];
            pz_reg <= pz_prod[46:24];
            xn_reg <= sx_reg && (dx_reg != 31'd0);
            yn_reg <= sy_reg && (cp_reg != 31'd0);
            zn_reg <= sz_reg && (dz_reg != 31'd0);
            nx_reg <= norm_field(dx_reg, sx_reg && (dx_reg != 31'd0));
            ny_reg <= norm_field(cp_reg, sy_reg && (cp_reg != 31'd0));
            nz_reg <= norm_field(dz_reg, sz_reg && (dz_reg != 31'd0));
        end
    end

    // output word: signs applied, vertex or fixed fields selected
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            if (ctl_reg[CTL_LAT-1].is_vtx)
            begin
                pos_x_reg  <= xn_reg ? (24'd0 - 24'(px_reg)) : 24'(px_reg);
                pos_y_reg  <= yn_reg ? (24'd0 - 24'(py_reg)) : 24'(py_reg);
                pos_z_reg  <= zn_reg ? (24'd0 - 24'(pz_reg)) : 24'(pz_reg);
                norm_x_reg <= nx_reg;
                norm_y_reg <= ny_reg;
                norm_z_reg <= nz_reg;
            end
            else
            begin
                pos_x_reg  <= '0;
                pos_y_reg  <= ctl_reg[CTL_LAT-1].pos_y;
                pos_z_reg  <= '0;
                norm_x_reg <= '0;
                norm_y_reg <= ctl_reg[CTL_LAT-1].norm_y;
                norm_z_reg <= '0;
            end
            tex_u_reg   <= ctl_reg[CTL_LAT-1].tex_u;
            tex_v_reg   <= ctl_reg[CTL_LAT-1].tex_v;
            index_a_reg <= ctl_reg[CTL_LAT-1].idx_a;
            index_b_reg <= ctl_reg[CTL_LAT-1].idx_b;
            index_c_reg <= ctl_reg[CTL_LAT-1].idx_c;
            bad_reg     <= ctl_reg[CTL_LAT-1].bad;
        end
    end

    assign out_valid   = out_valid_reg;
    assign pos_x       = $signed(pos_x_reg);
    assign pos_y       = $signed(pos_y_reg);
    assign pos_z       = $signed(pos_z_reg);
    assign norm_x      = $signed(norm_x_reg);
    assign norm_y      = $signed(norm_y_reg);
    assign norm_z      = $signed(norm_z_reg);
    assign tex_u       = tex_u_reg;
    assign tex_v       = tex_v_reg;
    assign index_a     = index_a_reg;
    assign index_b     = index_b_reg;
    assign index_c     = index_c_reg;
    assign bad_request = bad_reg;

    // an error word carries nothing but the flag
    a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && bad_request |-> (index_a == 17'd0) && (index_b == 17'd0) &&
            (index_c == 17'd0) && (tex_u == 17'd0) && (tex_v == 17'd0) && (pos_y == 24'sd0))
        else $error("error word carries nonzero fields");

    // a finished word moves to the output when the pipeline advances
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[CTL_LAT-1] && en |=> out_valid)
        else $error("finished word lost before output");

    // a triangle word carries no vertex attributes
    a_tri_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (index_b != 17'd0) |-> (norm_y == 16'sd0) && (tex_u == 17'd0) &&
            !bad_request)
        else $error("triangle word carries vertex fields");

endmodule
`default_nettype wire
